/* src/drap_pkg.sv */
package drap_pkg;

    localparam logic [7:0]  PTR_MASK  = 8'hC0;
    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] A_LENGTH  = 16'd4;
    localparam logic [15:0] QFIXED_LEN = 16'd4;
    localparam logic [3:0]  HDR_LAST  = 4'd11;
    localparam logic [3:0]  RR_LAST   = 4'd9;
    localparam logic [3:0]  ADDR_LAST = 4'd3;

    localparam logic [1:0] STATUS_IGNORED = 2'd0;
    localparam logic [1:0] STATUS_NO_ADDR = 2'd1;
    localparam logic [1:0] STATUS_FOUND   = 2'd2;

    typedef enum logic [11:0] {
        PH_HEADER = 12'h001,
        PH_QLABEL = 12'h002,
        PH_QSKIP  = 12'h004,
        PH_QPTR   = 12'h008,
        PH_QFIXED = 12'h010,
        PH_ALABEL = 12'h020,
        PH_ASKIP  = 12'h040,
        PH_APTR   = 12'h080,
        PH_AFIXED = 12'h100,
        PH_AADDR  = 12'h200,
        PH_ADATA  = 12'h400,
        PH_DONE   = 12'h800
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } t_out_word;

endpackage

/* src/dns_response_address_parser.sv */
// DNS reply address parser.
// Input channel (i_in_valid / o_in_ready / i_in_word): one payload byte per
// word, with last_byte set on the final byte of a reply. Output channel
// (o_out_valid / i_out_ready / o_out_word): one word per reply, given for the
// final byte, carrying status and the IPv4 address in network order.
// i_cfg_we / i_cfg_wdata load the expected transaction id; write it only
// while no reply is in flight.
// Each byte is taken into an input register, parsed by the combinational
// phase logic and, on the final byte, the result is loaded into the output
// register. o_out_valid rises once the final byte has moved from the input
// register into the output register. One byte is accepted every cycle while
// no result waits on a stalled receiver, with one pass through the phase logic.
// If the receiver stalls with a result waiting, the input register still
// takes one more byte if it is empty; after that o_in_ready stays low until
// the result is taken. Synchronous reset (i_rst_n low) empties both registers,
// returns the parser to the header phase and clears the expected id to zero.
module dns_response_address_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  drap_pkg::t_in_word        i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output drap_pkg::t_out_word       o_out_word,
    input  logic                      i_cfg_we,
    input  logic [15:0]               i_cfg_wdata
);

    logic                r_in_valid;
    drap_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    drap_pkg::t_out_word r_out_word;
    logic [15:0]         r_expected_id;

    drap_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_header_index, n_header_index;
    logic [31:0] r_id_flags, n_id_flags;
    logic [15:0] r_answers_left, n_answers_left;
    logic [15:0] r_skip_count, n_skip_count;
    logic [15:0] r_record_type, n_record_type;
    logic [15:0] r_record_length, n_record_length;
    logic [31:0] r_address, n_address;
    logic [1:0]  r_outcome, n_outcome;

    logic       advance;
    logic       consume;
    logic [7:0] b;

    assign advance     = !r_out_valid || i_out_ready;
    assign consume     = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign b           = r_in_word.data_byte;

    always_comb begin
        n_phase         = r_phase;
        n_header_index  = r_header_index;
        n_id_flags      = r_id_flags;
        n_answers_left  = r_answers_left;
        n_skip_count    = r_skip_count;
        n_record_type   = r_record_type;
        n_record_length = r_record_length;
        n_address       = r_address;
        n_outcome       = r_outcome;

        unique case (r_phase)
            drap_pkg::PH_HEADER: begin
                if (r_header_index < 4'd4) begin
                    n_id_flags = {r_id_flags[23:0], b};
                end else if (r_header_index == 4'd6) begin
                    n_answers_left = {b, 8'd0};
                end else if (r_header_index == 4'd7) begin
                    n_answers_left = {r_answers_left[15:8], b};
                end
                if (r_header_index >= drap_pkg::HDR_LAST) begin
                    n_header_index = '0;
                    if (n_id_flags[31:16] != r_expected_id || !n_id_flags[15]) begin
                        n_phase = drap_pkg::PH_DONE;
                    end else begin
                        n_outcome = drap_pkg::STATUS_NO_ADDR;
                        n_phase = (n_answers_left == '0) ? drap_pkg::PH_DONE
                                                          : drap_pkg::PH_QLABEL;
                    end
                end else begin
                    n_header_index = r_header_index + 4'd1;
                end
            end
            drap_pkg::PH_QLABEL, drap_pkg::PH_ALABEL: begin
                if (b == 8'd0) begin
                    if (r_phase == drap_pkg::PH_QLABEL) begin
                        n_skip_count = drap_pkg::QFIXED_LEN;
                        n_phase = drap_pkg::PH_QFIXED;
                    end else begin
                        n_header_index = '0;
                        n_phase = drap_pkg::PH_AFIXED;
                    end
                end else if ((b & drap_pkg::PTR_MASK) == drap_pkg::PTR_MASK) begin
                    n_phase = (r_phase == drap_pkg::PH_QLABEL) ? drap_pkg::PH_QPTR
                                                               : drap_pkg::PH_APTR;
                end else begin
                    n_skip_count = {8'd0, b};
                    n_phase = (r_phase == drap_pkg::PH_QLABEL) ? drap_pkg::PH_QSKIP
                                                               : drap_pkg::PH_ASKIP;
                end
            end
            drap_pkg::PH_QSKIP: begin
                n_skip_count = r_skip_count - 16'd1;
                if (n_skip_count == '0) begin
                    n_phase = drap_pkg::PH_QLABEL;
                end
            end
            drap_pkg::PH_QPTR: begin
                n_skip_count = drap_pkg::QFIXED_LEN;
                n_phase = drap_pkg::PH_QFIXED;
            end
            drap_pkg::PH_QFIXED: begin
                n_skip_count = r_skip_count - 16'd1;
                if (n_skip_count == '0) begin
                    n_phase = drap_pkg::PH_ALABEL;
                end
            end
            drap_pkg::PH_ASKIP: begin
                n_skip_count = r_skip_count - 16'd1;
                if (n_skip_count == '0) begin
                    n_phase = drap_pkg::PH_ALABEL;
                end
            end
            drap_pkg::PH_APTR: begin
                n_header_index = '0;
                n_phase = drap_pkg::PH_AFIXED;
            end
            drap_pkg::PH_AFIXED: begin
                if (r_header_index == 4'd0) begin
                    n_record_type = {b, 8'd0};
                end else if (r_header_index == 4'd1) begin
                    n_record_type = {r_record_type[15:8], b};
                end else if (r_header_index == 4'd8) begin
                    n_record_length = {b, 8'd0};
                end else if (r_header_index == 4'd9) begin
                    n_record_length = {r_record_length[15:8], b};
                end
                if (r_header_index >= drap_pkg::RR_LAST) begin
                    n_header_index = '0;
                    if (n_record_type == drap_pkg::TYPE_A &&
                        n_record_length == drap_pkg::A_LENGTH) begin
                        n_address = '0;
                        n_phase = drap_pkg::PH_AADDR;
                    end else if (n_record_length == '0) begin
                        n_answers_left = r_answers_left - 16'd1;
                        n_phase = (n_answers_left == '0) ? drap_pkg::PH_DONE
                                                          : drap_pkg::PH_ALABEL;
                    end else begin
                        n_skip_count = n_record_length;
                        n_phase = drap_pkg::PH_ADATA;
                    end
                end else begin
                    n_header_index = r_header_index + 4'd1;
                end
            end
            drap_pkg::PH_AADDR: begin
                n_address = {r_address[23:0], b};
                if (r_header_index >= drap_pkg::ADDR_LAST) begin
                    n_header_index = '0;
                    n_outcome = drap_pkg::STATUS_FOUND;
                    n_phase = drap_pkg::PH_DONE;
                end else begin
                    n_header_index = r_header_index + 4'd1;
                end
            end
            drap_pkg::PH_ADATA: begin
                n_skip_count = r_skip_count - 16'd1;
                if (n_skip_count == '0) begin
                    n_answers_left = r_answers_left - 16'd1;
                    n_phase = (n_answers_left == '0) ? drap_pkg::PH_DONE
                                                      : drap_pkg::PH_ALABEL;
                end
            end
            default: begin
                n_phase = drap_pkg::PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_expected_id   <= '0;
            r_phase         <= drap_pkg::PH_HEADER;
            r_header_index  <= '0;
            r_id_flags      <= '0;
            r_answers_left  <= '0;
            r_skip_count    <= '0;
            r_record_type   <= '0;
            r_record_length <= '0;
            r_address       <= '0;
            r_outcome       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_expected_id <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= consume && r_in_word.last_byte;
            end
            if (consume) begin
                if (r_in_word.last_byte) begin
                    r_phase         <= drap_pkg::PH_HEADER;
                    r_header_index  <= '0;
                    r_id_flags      <= '0;
                    r_answers_left  <= '0;
                    r_skip_count    <= '0;
                    r_record_type   <= '0;
                    r_record_length <= '0;
                    r_address       <= '0;
                    r_outcome       <= '0;
                end else begin
                    r_phase         <= n_phase;
                    r_header_index  <= n_header_index;
                    r_id_flags      <= n_id_flags;
                    r_answers_left  <= n_answers_left;
                    r_skip_count    <= n_skip_count;
                    r_record_type   <= n_record_type;
                    r_record_length <= n_record_length;
                    r_address       <= n_address;
                    r_outcome       <= n_outcome;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (consume && r_in_word.last_byte) begin
            r_out_word.status  <= n_outcome;
            r_out_word.address <= (n_outcome == drap_pkg::STATUS_FOUND) ? n_address : '0;
        end
    end

    a_rose_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_word.last_byte))
        else $error("result without final byte");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status != drap_pkg::STATUS_FOUND)
            |-> (r_out_word.address == '0))
        else $error("address nonzero without found status");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_word.last_byte)
            |=> (r_phase == drap_pkg::PH_HEADER && r_header_index == '0))
        else $error("parser not back in header phase");

    a_outcome_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && !r_in_word.last_byte) |=> (r_outcome >= $past(r_outcome)))
        else $error("outcome fell within a reply");

endmodule
